FILE: src/fork_token_mutex_controller_assert.svh
// Assertion macros used by the fork token mutex controller sequencer.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FORK_TOKEN_MUTEX_CONTROLLER_ASSERT_SVH
`define FORK_TOKEN_MUTEX_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTMC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ftmc_pkg.sv
// Package of the fork token mutex controller: widths, codes, phase and
// sequencer types, and the structs between the sequencer and the fork cells.
package ftmc_pkg;

    localparam int MAX_PEERS  = 15;
    localparam int PEER_W     = $clog2(MAX_PEERS + 1);
    localparam int CNT_W      = $clog2(MAX_PEERS + 2);
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int DEST_W     = 4;
    localparam int ID_W       = 4;
    localparam int PC_W       = 5;
    localparam int DONE_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Common width for comparing ids, counts and the done counter.
    localparam int CMP_A = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int CMP_B = (PC_W > DONE_W) ? PC_W : DONE_W;
    localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEER_REQ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORK_RCVD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEER_DONE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_FORK_REQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HANDOVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTERED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'b1;

    localparam logic [ID_W-1:0]   SELF_ID_RESET    = 4'd1;
    localparam logic [PC_W-1:0]   PROC_COUNT_RESET = 5'd3;
    localparam logic [DONE_W-1:0] DONE_MAX         = '1;

    typedef enum logic [1:0] {
        PH_THINKING = 2'd0,
        PH_HUNGRY   = 2'd1,
        PH_EATING   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REREQ,
        S_CHECK,
        S_FLUSH
    } t_state;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             shift;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  peer;
        t_phase           phase;
        logic             initialized;
        logic [ID_W-1:0]  self_id;
        logic [CMP_W-1:0] eff_count;
    } t_cell_ctl;

    // Report of one cell; all zero unless the cell holds the scan token.
    typedef struct packed {
        logic              active;
        logic [PEER_W-1:0] index;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              usable;
    } t_cell_status;

endpackage

FILE: src/ftmc_fork_cell.sv
// One fork cell: held, clean and awaited bits of one peer, plus a scan token stage.
// Depends on ftmc_pkg.
module ftmc_fork_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ftmc_pkg::PEER_W-1:0] i_index,
    input  ftmc_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_tok_in,
    output logic                      o_tok,
    output ftmc_pkg::t_cell_status    o_status
);
    import ftmc_pkg::*;

    logic              r_held, r_clean, r_awaited, r_tok;
    logic              n_held, n_clean, n_awaited;
    logic              w_h, w_c, w_a;
    logic              w_counted, w_is_peer, w_in_range, w_at_or_above;
    logic              w_emit;
    logic [KIND_W-1:0] w_kind;
    logic [CMP_W-1:0]  w_idx;

    always_comb begin
        w_idx         = CMP_W'(i_index);
        w_in_range    = w_idx < i_ctl.eff_count;
        w_at_or_above = w_idx >= CMP_W'(i_ctl.self_id);
        w_counted     = w_in_range && (w_idx != CMP_W'(i_ctl.self_id));
        w_is_peer     = w_idx == CMP_W'(i_ctl.peer);

        // The first request sets the fork bits up from the node id.
        if (i_ctl.cmd == CMD_REQUEST && !i_ctl.initialized) begin
            w_h = w_in_range && w_at_or_above;
            w_c = w_in_range && !w_at_or_above;
            w_a = w_in_range && !w_at_or_above;
        end else begin
            w_h = r_held;
            w_c = r_clean;
            w_a = r_awaited;
        end

        n_held    = w_h;
        n_clean   = w_c;
        n_awaited = w_a;
        w_emit    = 1'b0;
        w_kind    = KIND_FORK_REQ;

        case (i_ctl.cmd)
            CMD_REQUEST: begin
                if (w_counted && !w_h) begin
                    w_emit    = 1'b1;
                    n_awaited = 1'b0;
                end
            end
            CMD_RELEASE: begin
                if (w_counted) begin
                    n_clean = 1'b0;
                    if (w_a) begin
                        n_held    = 1'b0;
                        n_awaited = 1'b0;
                        w_emit    = 1'b1;
                        w_kind    = KIND_HANDOVER;
                    end
                end
            end
            CMD_PEER_REQ: begin
                if (w_counted && w_is_peer) begin
                    n_awaited = 1'b1;
                    if (i_ctl.phase != PH_EATING && !w_c) begin
                        n_held    = 1'b0;
                        n_clean   = 1'b1;
                        n_awaited = 1'b0;
                        w_emit    = 1'b1;
                        w_kind    = KIND_HANDOVER;
                    end
                end
            end
            CMD_FORK_RCVD: begin
                if (w_counted && w_is_peer) begin
                    n_held  = 1'b1;
                    n_clean = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_clean   <= 1'b0;
            r_awaited <= 1'b0;
            r_tok     <= 1'b0;
        end else if (i_ctl.shift) begin
            r_tok <= i_tok_in;
            if (r_tok) begin
                r_held    <= n_held;
                r_clean   <= n_clean;
                r_awaited <= n_awaited;
            end
        end
    end

    assign o_tok           = r_tok;
    assign o_status.active = r_tok;
    assign o_status.index  = r_tok ? i_index : '0;
    assign o_status.emit   = r_tok & w_emit;
    assign o_status.kind   = r_tok ? w_kind : '0;
    assign o_status.usable = r_tok & w_counted & n_held & (n_clean | ~n_awaited);

endmodule

FILE: src/ftmc_sequencer.sv
// Sequencer of the fork token mutex controller: configuration, phase, done
// counter, scan control, entry check and the result output stages.
// Depends on ftmc_pkg and fork_token_mutex_controller_assert.svh.
`include "fork_token_mutex_controller_assert.svh"

module ftmc_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ftmc_pkg::CMD_W-1:0]     i_command,
    input  logic [ftmc_pkg::ID_W-1:0]      i_peer,
    input  logic                           i_cfg_we,
    input  logic [ftmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ftmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ftmc_pkg::KIND_W-1:0]    o_kind,
    output logic [ftmc_pkg::DEST_W-1:0]    o_dest,
    output logic                           o_last,
    output ftmc_pkg::t_cell_ctl            o_ctl,
    output logic                           o_start,
    input  ftmc_pkg::t_cell_status         i_status [ftmc_pkg::MAX_PEERS],
    input  logic [ftmc_pkg::MAX_PEERS-1:0] i_tokens
);
    import ftmc_pkg::*;

    t_state              r_state, n_state;
    logic [ID_W-1:0]     r_self_id;
    logic [PC_W-1:0]     r_proc_count;
    t_phase              r_phase;
    logic [DONE_W-1:0]   r_done;
    logic                r_init;
    logic [CMD_W-1:0]    r_cmd;
    logic [ID_W-1:0]     r_peer;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_rereq;
    logic                r_pend_v;
    logic [KIND_W-1:0]   r_pend_kind;
    logic [DEST_W-1:0]   r_pend_dest;
    logic                r_out_v;
    logic [KIND_W-1:0]   r_out_kind;
    logic [DEST_W-1:0]   r_out_dest;
    logic                r_out_last;

    logic [$bits(t_cell_status)-1:0] w_st_bits;
    t_cell_status        w_st;
    logic [CMP_W-1:0]    w_pc, w_eff, w_need;
    logic                w_accept, w_cmd_ok, w_start;
    logic                w_out_free, w_emit_ok, w_adv, w_shift, w_last_cell;
    logic                w_set_rereq, w_enter, w_flush;
    logic                w_emit;
    logic [KIND_W-1:0]   w_ekind;
    logic [DEST_W-1:0]   w_edest;

    // Only the cell with the token reports, so an OR picks its status.
    always_comb begin
        w_st_bits = '0;
        for (int k = 0; k < MAX_PEERS; k++) begin
            w_st_bits = w_st_bits | i_status[k];
        end
        w_st = t_cell_status'(w_st_bits);
    end

    always_comb begin
        w_pc = CMP_W'(r_proc_count);
        if (w_pc < CMP_W'(2)) begin
            w_eff = CMP_W'(2);
        end else if (w_pc > CMP_W'(MAX_PEERS + 1)) begin
            w_eff = CMP_W'(MAX_PEERS + 1);
        end else begin
            w_eff = w_pc;
        end
        w_need = w_eff - CMP_W'(2);
    end

    always_comb begin
        w_enter = 1'b0;
        case (r_cmd) inside
            CMD_REQUEST: begin
                w_enter = (CMP_W'(r_cnt) == w_need) && (CMP_W'(r_done) == w_need);
            end
            CMD_PEER_REQ, CMD_FORK_RCVD, CMD_PEER_DONE: begin
                w_enter = (r_phase == PH_HUNGRY) && (CMP_W'(r_cnt) == w_need);
            end
            default: begin
                w_enter = 1'b0;
            end
        endcase
    end

    // Handshake and datapath controls.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_accept    = i_in_valid && o_in_ready;
        w_cmd_ok    = i_command <= CMD_PEER_DONE;
        w_start     = w_accept && w_cmd_ok;
        w_out_free  = !r_out_v || i_out_ready;
        w_emit_ok   = !r_pend_v || w_out_free;
        w_adv       = (r_state == S_SCAN) && (!w_st.emit || w_emit_ok);
        w_shift     = w_start || w_adv;
        w_last_cell = w_st.active && (w_st.index == PEER_W'(MAX_PEERS));
        w_set_rereq = (r_cmd == CMD_PEER_REQ) && (r_phase == PH_HUNGRY) && w_st.emit;
        w_flush     = (r_state == S_FLUSH) && r_pend_v && w_out_free;
        w_emit      = 1'b0;
        w_ekind     = KIND_FORK_REQ;
        w_edest     = '0;
        unique case (r_state)
            S_SCAN: begin
                w_emit  = w_st.emit && w_emit_ok;
                w_ekind = w_st.kind;
                w_edest = DEST_W'(w_st.index);
            end
            S_REREQ: begin
                w_emit  = w_emit_ok;
                w_ekind = KIND_FORK_REQ;
                w_edest = DEST_W'(r_peer);
            end
            S_CHECK: begin
                w_emit  = w_enter && w_emit_ok;
                w_ekind = KIND_ENTERED;
                w_edest = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_adv && w_last_cell) begin
                    n_state = (r_rereq || w_set_rereq) ? S_REREQ : S_CHECK;
                end
            end
            S_REREQ: begin
                if (w_emit_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_enter || w_emit_ok) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_self_id    <= SELF_ID_RESET;
            r_proc_count <= PROC_COUNT_RESET;
            r_phase      <= PH_THINKING;
            r_done       <= '0;
            r_init       <= 1'b0;
            r_rereq      <= 1'b0;
            r_cnt        <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SELF_ID:       r_self_id    <= i_cfg_data[ID_W-1:0];
                    REG_PROCESS_COUNT: r_proc_count <= i_cfg_data[PC_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_accept) begin
                if (i_command == CMD_REQUEST) begin
                    r_phase <= PH_HUNGRY;
                end else if (i_command == CMD_RELEASE) begin
                    r_phase <= PH_THINKING;
                end
                if (i_command == CMD_PEER_DONE && r_done != DONE_MAX) begin
                    r_done <= r_done + DONE_W'(1);
                end
            end else if (r_state == S_CHECK && w_enter && w_emit_ok) begin
                r_phase <= PH_EATING;
            end

            if (r_state == S_CHECK && r_cmd == CMD_REQUEST) begin
                r_init <= 1'b1;
            end

            if (w_start) begin
                r_cnt   <= '0;
                r_rereq <= 1'b0;
            end else if (w_adv) begin
                r_cnt <= r_cnt + CNT_W'(w_st.usable);
                if (w_set_rereq) begin
                    r_rereq <= 1'b1;
                end
            end

            // The newest result waits in the pending stage until it is known
            // whether another one follows it.
            if (w_emit) begin
                r_pend_v <= 1'b1;
            end else if (w_flush) begin
                r_pend_v <= 1'b0;
            end

            if ((w_emit && r_pend_v) || w_flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_peer <= i_peer;
        end
        if (w_emit) begin
            r_pend_kind <= w_ekind;
            r_pend_dest <= w_edest;
        end
        if ((w_emit && r_pend_v) || w_flush) begin
            r_out_kind <= r_pend_kind;
            r_out_dest <= r_pend_dest;
            r_out_last <= w_flush;
        end
    end

    assign o_start           = w_start;
    assign o_ctl.shift       = w_shift;
    assign o_ctl.cmd         = w_start ? i_command : r_cmd;
    assign o_ctl.peer        = r_peer;
    assign o_ctl.phase       = r_phase;
    assign o_ctl.initialized = r_init;
    assign o_ctl.self_id     = r_self_id;
    assign o_ctl.eff_count   = w_eff;
    assign o_out_valid       = r_out_v;
    assign o_kind            = r_out_kind;
    assign o_dest            = r_out_dest;
    assign o_last            = r_out_last;

    `FTMC_ASSERT_IMP(a_scan_one_token, r_state == S_SCAN, $onehot(i_tokens), "scan lost its token")
    `FTMC_ASSERT_IMP(a_idle_no_pending, r_state == S_IDLE, !r_pend_v, "result left pending in idle")
    `FTMC_ASSERT_NXT(a_flush_marks_last, w_flush, o_out_valid && o_last, "flush did not mark last")

endmodule

FILE: src/fork_token_mutex_controller.sv
// Top level of the fork token mutex controller: a sequencer and a chain of fork cells.
// Depends on ftmc_pkg, ftmc_sequencer and ftmc_fork_cell.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_command, i_peer
// result    out        o_out_valid / i_out_ready    o_kind, o_dest, o_last
// config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// A known command scans the fork cells in turn (MAX_PEERS of them), then sends a due
// re-request, does the entry check and releases the final result; the block takes a
// new command only after the previous one has finished.
// An unknown command is taken without a scan. A stalled output holds the scan on the
// cell that wants to emit; new input waits until the last result of the previous
// transaction has moved into the output register.
// Reset is synchronous and clears all fork bits, phase and counters at once.
module fork_token_mutex_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ftmc_pkg::CMD_W-1:0]      i_command,
    input  logic [ftmc_pkg::ID_W-1:0]       i_peer,
    input  logic                            i_cfg_we,
    input  logic [ftmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ftmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ftmc_pkg::KIND_W-1:0]     o_kind,
    output logic [ftmc_pkg::DEST_W-1:0]     o_dest,
    output logic                            o_last
);
    import ftmc_pkg::*;

    t_cell_ctl              w_ctl;
    t_cell_status           w_status [MAX_PEERS];
    logic [MAX_PEERS-1:0]   w_tok;
    logic                   w_start;

    // The sequencer owns configuration, phase and the output stages; it
    // broadcasts the current command to all cells and starts the token walk.
    ftmc_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_peer      (i_peer),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_dest      (o_dest),
        .o_last      (o_last),
        .o_ctl       (w_ctl),
        .o_start     (w_start),
        .i_status    (w_status),
        .i_tokens    (w_tok)
    );

    // Cell g serves peer g+1. The token enters at the first cell and moves one
    // cell per shift, so messages come out in ascending peer order.
    for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
        logic w_tok_in;
        if (g == 0) begin : g_head
            assign w_tok_in = w_start;
        end else begin : g_body
            assign w_tok_in = w_tok[g-1];
        end
        ftmc_fork_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (PEER_W'(g + 1)),
            .i_ctl    (w_ctl),
            .i_tok_in (w_tok_in),
            .o_tok    (w_tok[g]),
            .o_status (w_status[g])
        );
    end

endmodule

FILE: bench/tb_fork_token_mutex_controller.sv
// Self-checking testbench of the fork token mutex controller, top module included.
// Depends on ftmc_pkg and on the fork_token_mutex_controller RTL under test.
// The bench drives a directed table, then random phases, and checks every result.
module tb_fork_token_mutex_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ftmc_pkg::*;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int GAP_MAX         = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int MSG_LIMIT       = 16;
    localparam int SHOWN_ERRORS    = 10;
    localparam int TIMEOUT_NS      = 2_000_000;

    // One outgoing message of the block.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DEST_W-1:0] dest;
        logic              last;
    } t_msg;

    // One line of the directed table: either a register write or an event.
    // When typed is set, the bench expects one result if typed_n is positive and
    // none otherwise, and the only result that is ever typed in is the entered message.
    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [CMD_W-1:0]      cmd;
        logic [ID_W-1:0]       peer;
        logic                  typed;
        int                    typed_n;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command   = '0;
    logic [ID_W-1:0]       i_peer      = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [DEST_W-1:0]     o_dest;
    logic                  o_last;

    fork_token_mutex_controller dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the controller: configuration, fork bits and phase.
    logic [ID_W-1:0]   m_self  = SELF_ID_RESET;
    logic [PC_W-1:0]   m_procs = PROC_COUNT_RESET;
    logic [15:0]       m_held    = '0;
    logic [15:0]       m_clean   = '0;
    logic [15:0]       m_awaited = '0;
    t_phase            m_phase   = PH_THINKING;
    logic [DONE_W-1:0] m_done    = '0;
    logic              m_init    = 1'b0;

    // Messages that the current event causes, and every message still owed
    // by the block in the order it must hand them over.
    t_msg item_msgs[$];
    t_msg pending_msgs[$];

    int   fail_count = 0;
    logic tx_steady  = 1'b0;
    logic rx_steady  = 1'b0;
    logic rx_hold    = 1'b0;
    logic hold_go    = 1'b0;
    int   rx_gap     = 0;
    t_row dir_rows[$];

    // The process count as the block sees it, kept inside 2 .. MAX_PEERS+1.
    function automatic int eff_procs();
        int p = int'(m_procs);
        if (p < 2) p = 2;
        if (p > MAX_PEERS + 1) p = MAX_PEERS + 1;
        return p;
    endfunction

    function automatic logic is_counted(int i);
        return (i >= 1) && (i < eff_procs()) && (i != int'(m_self));
    endfunction

    function automatic void add_msg(logic [KIND_W-1:0] kind, int dest);
        if (item_msgs.size() < MSG_LIMIT) item_msgs.push_back('{kind, DEST_W'(dest), 1'b0});
    endfunction

    // Entry needs exactly the needed number of held forks that are clean or
    // not wanted by their peer; the check on a request also wants all peers done.
    function automatic void try_entry(logic need_done);
        int usable = 0;
        int need = eff_procs() - 2;
        for (int i = 1; i < eff_procs(); i++) begin
            if (is_counted(i) && m_held[i] && (m_clean[i] || !m_awaited[i])) usable++;
        end
        if (usable != need) return;
        if (need_done && int'(m_done) != need) return;
        m_phase = PH_EATING;
        add_msg(KIND_ENTERED, 0);
    endfunction

    // Advances the shadow state by one event and leaves its messages in item_msgs.
    function automatic void compute_messages(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] peer);
        int p = int'(peer);
        item_msgs.delete();
        case (cmd)
            CMD_REQUEST: begin
                // The first request lays out the forks from this node's id:
                // higher ids start held and dirty, lower ids clean and awaited.
                if (!m_init) begin
                    m_held = '0;
                    m_clean = '0;
                    m_awaited = '0;
                    m_phase = PH_THINKING;
                    for (int i = 1; i < eff_procs(); i++) begin
                        if (i >= int'(m_self)) begin
                            m_held[i] = 1'b1;
                        end else begin
                            m_clean[i] = 1'b1;
                            m_awaited[i] = 1'b1;
                        end
                    end
                    m_init = 1'b1;
                end
                m_phase = PH_HUNGRY;
                for (int i = 1; i < eff_procs(); i++) begin
                    if (is_counted(i) && !m_held[i]) begin
                        add_msg(KIND_FORK_REQ, i);
                        m_awaited[i] = 1'b0;
                    end
                end
                try_entry(1'b1);
            end
            CMD_RELEASE: begin
                m_phase = PH_THINKING;
                for (int i = 1; i < eff_procs(); i++) begin
                    if (is_counted(i)) m_clean[i] = 1'b0;
                end
                for (int i = 1; i < eff_procs(); i++) begin
                    if (is_counted(i) && m_awaited[i]) begin
                        m_held[i] = 1'b0;
                        add_msg(KIND_HANDOVER, i);
                        m_awaited[i] = 1'b0;
                    end
                end
            end
            CMD_PEER_REQ: begin
                if (is_counted(p)) begin
                    m_awaited[p] = 1'b1;
                    // While eating the request is only remembered.
                    if (m_phase != PH_EATING && !m_clean[p]) begin
                        m_held[p] = 1'b0;
                        m_clean[p] = 1'b1;
                        add_msg(KIND_HANDOVER, p);
                        m_awaited[p] = 1'b0;
                        if (m_phase == PH_HUNGRY) add_msg(KIND_FORK_REQ, p);
                    end
                end
                if (m_phase == PH_HUNGRY) try_entry(1'b0);
            end
            CMD_FORK_RCVD: begin
                if (is_counted(p)) begin
                    m_held[p] = 1'b1;
                    m_clean[p] = 1'b1;
                end
                if (m_phase == PH_HUNGRY) try_entry(1'b0);
            end
            CMD_PEER_DONE: begin
                if (m_done != DONE_MAX) m_done = m_done + 1'b1;
                if (m_phase == PH_HUNGRY) try_entry(1'b0);
            end
            default: begin
            end
        endcase
        if (item_msgs.size() > 0) item_msgs[item_msgs.size() - 1].last = 1'b1;
    endfunction

    function automatic t_row ev(logic [CMD_W-1:0] cmd, int peer, logic typed, int typed_n);
        t_row r;
        r.is_cfg = 1'b0;
        r.idx = '0;
        r.data = '0;
        r.cmd = cmd;
        r.peer = ID_W'(peer);
        r.typed = typed;
        r.typed_n = typed_n;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        t_row r;
        r = ev(CMD_RSVD5, 0, 1'b0, 0);
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = CFG_DATA_W'(data);
        return r;
    endfunction

    // Offers one event to the block and, once the transaction is taken, queues
    // what it must answer. The sender may pause before each offer.
    task automatic offer_event(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] peer,
                               logic typed, int typed_n);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
        compute_messages(cmd, peer);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_peer     <= peer;
        do @(posedge i_clk); while (!o_in_ready);
        if (typed) begin
            if (typed_n > 0) pending_msgs.push_back('{KIND_ENTERED, DEST_W'(0), 1'b1});
        end else begin
            foreach (item_msgs[k]) pending_msgs.push_back(item_msgs[k]);
        end
    endtask

    // Waits until every owed message is out, then gives the block time to
    // finish an event that answers nothing.
    task automatic drain_to_idle();
        i_in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_to_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == REG_SELF_ID) m_self = data[ID_W-1:0];
        else m_procs = data[PC_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: checks every result transaction against the oldest owed
    // message and then stays away for a drawn number of cycles. A long hold
    // from the stall process below overrides the ready it would raise.
    always @(posedge i_clk) begin
        int   next_gap;
        t_msg want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            next_gap = (rx_gap > 0) ? rx_gap - 1 : 0;
            if (o_out_valid && i_out_ready) begin
                if (pending_msgs.size() == 0) begin
                    if (fail_count < SHOWN_ERRORS)
                        $display("%0t: unexpected result kind=%0d dest=%0d last=%0d",
                                 $realtime, o_kind, o_dest, o_last);
                    fail_count++;
                end else begin
                    want = pending_msgs.pop_front();
                    if (want.kind !== o_kind || want.dest !== o_dest || want.last !== o_last) begin
                        if (fail_count < SHOWN_ERRORS)
                            $display("%0t: result mismatch, expected kind=%0d dest=%0d last=%0d, got kind=%0d dest=%0d last=%0d",
                                     $realtime, want.kind, want.dest, want.last,
                                     o_kind, o_dest, o_last);
                        fail_count++;
                    end
                end
                next_gap = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
            end
            rx_gap <= next_gap;
            i_out_ready <= (next_gap == 0) && !rx_hold;
        end
    end

    // Long receiver stall: the block fills with owed messages and must stop
    // taking input transactions while the sender keeps offering.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int             procs_v;
        int             r;
        int             peer_v;
        logic [CMD_W-1:0] cmd_v;
        int             missing[$];

        // Directed part, starting from the reset setting of node one among three.
        // Ignored commands and events before the first request answer nothing.
        dir_rows.push_back(ev(CMD_RSVD5, 15, 1'b1, 0));
        dir_rows.push_back(ev(CMD_RSVD7, 0, 1'b1, 0));
        dir_rows.push_back(ev(CMD_RSVD6, 9, 1'b1, 0));
        dir_rows.push_back(ev(CMD_PEER_DONE, 0, 1'b1, 0));
        dir_rows.push_back(ev(CMD_FORK_RCVD, 2, 1'b1, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 2, 1'b0, 0));
        // First request: node one holds every fork and its one peer is done.
        dir_rows.push_back(ev(CMD_REQUEST, 0, 1'b1, 1));
        // A peer request while eating is deferred; a repeated request re-checks.
        dir_rows.push_back(ev(CMD_PEER_REQ, 2, 1'b0, 0));
        dir_rows.push_back(ev(CMD_REQUEST, 7, 1'b0, 0));
        dir_rows.push_back(ev(CMD_RELEASE, 0, 1'b0, 0));
        // Peers that are zero, this node itself, or beyond the count.
        dir_rows.push_back(ev(CMD_PEER_REQ, 0, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 1, 1'b0, 0));
        dir_rows.push_back(ev(CMD_FORK_RCVD, 3, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 15, 1'b0, 0));
        // Widest setting: a request sends one fork request per missing fork.
        dir_rows.push_back(reg_row(REG_PROCESS_COUNT, MAX_PEERS + 1));
        dir_rows.push_back(reg_row(REG_SELF_ID, 15));
        dir_rows.push_back(ev(CMD_REQUEST, 0, 1'b0, 0));
        dir_rows.push_back(ev(CMD_FORK_RCVD, 14, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 14, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_DONE, 15, 1'b0, 0));
        dir_rows.push_back(ev(CMD_RELEASE, 0, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 5, 1'b0, 0));
        // Narrowest setting: no forks are needed, so the re-check enters at once
        // even though the done count no longer matches.
        dir_rows.push_back(reg_row(REG_SELF_ID, 1));
        dir_rows.push_back(reg_row(REG_PROCESS_COUNT, 2));
        dir_rows.push_back(ev(CMD_REQUEST, 0, 1'b0, 0));
        dir_rows.push_back(ev(CMD_PEER_REQ, 1, 1'b0, 0));
        dir_rows.push_back(ev(CMD_RELEASE, 0, 1'b0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) program_reg(dir_rows[k].idx, dir_rows[k].data);
            else offer_event(dir_rows[k].cmd, dir_rows[k].peer,
                             dir_rows[k].typed, dir_rows[k].typed_n);
        end

        // Random phases, each under a fresh setting. Most events follow the
        // protocol (requests to counted peers, forks that are actually
        // missing), the rest is noise on the full field ranges.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            procs_v = $urandom_range(2, MAX_PEERS + 1);
            program_reg(REG_SELF_ID, CFG_DATA_W'($urandom_range(1, 15)));
            program_reg(REG_PROCESS_COUNT, CFG_DATA_W'(procs_v));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 1 && n == 5) hold_go = 1'b1;
                r = $urandom_range(0, 99);
                peer_v = ($urandom_range(0, 4) != 0) ? $urandom_range(1, eff_procs() - 1)
                                                      : $urandom_range(0, 15);
                if (r < 12) begin
                    cmd_v = CMD_REQUEST;
                end else if (r < 24) begin
                    cmd_v = CMD_RELEASE;
                end else if (r < 46) begin
                    cmd_v = CMD_PEER_REQ;
                end else if (r < 68) begin
                    cmd_v = CMD_FORK_RCVD;
                    missing.delete();
                    for (int i = 1; i < eff_procs(); i++)
                        if (is_counted(i) && !m_held[i]) missing.push_back(i);
                    if (missing.size() > 0 && $urandom_range(0, 4) != 0)
                        peer_v = missing[$urandom_range(0, missing.size() - 1)];
                end else if (r < 88) begin
                    cmd_v = CMD_PEER_DONE;
                end else begin
                    cmd_v = CMD_W'($urandom_range(int'(CMD_RSVD5), int'(CMD_RSVD7)));
                end
                offer_event(cmd_v, ID_W'(peer_v), 1'b0, 0);
            end
        end

        drain_to_idle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
